FILE: hdl/ofap_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the OTP fuse array program unit.
// Used by ofap_bank_ram, ofap_rmw_ctrl and otp_fuse_array_program_unit.
package ofap_pkg;

  // Field widths of one command and one response
  localparam int CMD_W    = 2;
  localparam int OFF_W    = 10;
  localparam int CNT_W    = 4;
  localparam int DATA_W   = 64;
  localparam int STATUS_W = 3;
  localparam int FLAG_W   = 32;

  // Byte lanes: one memory bank per byte address modulo LANES
  localparam int BYTE_W = 8;
  localparam int LANES  = 8;
  localparam int LANE_W = 3;

  localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;
  localparam int FINAL_LOCK_BIT = 0;

  // Defaults for the top-level parameters
  localparam int DEFAULT_ARRAY_BYTES      = 1024;
  localparam int DEFAULT_MAX_ACCESS_BYTES = 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_READ      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PROGRAM   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET_FLAGS = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOCKED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SETBIT   = 3'd4;

  // Per-cycle control from the sequencer to the byte banks
  typedef struct packed {
    logic             rd;
    logic [LANES-1:0] wr;
  } ofap_bank_ctl_t;

endpackage

FILE: hdl/ofap_bank_ram.sv
`timescale 1ns / 1ps
// One byte-wide bank of the fuse array: single port, registered read data.
// Depends on ofap_pkg for the byte width.
module ofap_bank_ram #(
  parameter int ROWS  = 128,
  parameter int ROW_W = 7
) (
  input  logic                      clk,
  input  logic [ROW_W-1:0]          addr,
  input  logic                      rd,
  input  logic                      wr,
  input  logic [ofap_pkg::BYTE_W-1:0] wdata,
  output logic [ofap_pkg::BYTE_W-1:0] rdata
);
  import ofap_pkg::*;

  logic [BYTE_W-1:0] mem [ROWS];

  // Write and read the addressed row
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[addr] <= wdata;
    end
    if (rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: hdl/ofap_rmw_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer: erase pass, bank read, checks, write-back, flags, response.
// Depends on ofap_pkg; drives the ofap_bank_ram instances in the top level.
module ofap_rmw_ctrl #(
  parameter int ARRAY_BYTES      = ofap_pkg::DEFAULT_ARRAY_BYTES,
  parameter int MAX_ACCESS_BYTES = ofap_pkg::DEFAULT_MAX_ACCESS_BYTES,
  parameter int ROWS             = 128,
  parameter int ROW_W            = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  // command side
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ofap_pkg::CMD_W-1:0]    command,
  input  logic [ofap_pkg::OFF_W-1:0]    byte_offset,
  input  logic [ofap_pkg::CNT_W-1:0]    byte_count,
  input  logic [ofap_pkg::DATA_W-1:0]   write_data,
  // response side
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ofap_pkg::STATUS_W-1:0] status,
  output logic [ofap_pkg::DATA_W-1:0]   read_data,
  output logic [ofap_pkg::FLAG_W-1:0]   flags_now,
  // bank side
  output ofap_pkg::ofap_bank_ctl_t      bank_ctl,
  output logic [ROW_W-1:0]              bank_row   [ofap_pkg::LANES],
  output logic [ofap_pkg::BYTE_W-1:0]   bank_wdata [ofap_pkg::LANES],
  input  logic [ofap_pkg::BYTE_W-1:0]   bank_rdata [ofap_pkg::LANES]
);
  import ofap_pkg::*;

  localparam int SPAN_W = ($clog2(ARRAY_BYTES + 1) > OFF_W + 1) ?
                          $clog2(ARRAY_BYTES + 1) : OFF_W + 1;
  localparam int ROWF_W = OFF_W - LANE_W + 1;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RMW} state_t;

  state_t              state;
  logic [ROW_W-1:0]    clr_row;
  logic [CMD_W-1:0]    cmd_q;
  logic [OFF_W-1:0]    off_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DATA_W-1:0]   data_q;
  logic [ROW_W-1:0]    row_q [LANES];
  logic [FLAG_W-1:0]   flags;

  logic [ROW_W-1:0]    row_acc [LANES];
  logic [LANE_W-1:0]   lane_idx [LANES];
  logic [LANES-1:0]    lane_act;
  logic [LANES-1:0]    setbit_hit;
  logic [BYTE_W-1:0]   new_byte [LANES];
  logic [DATA_W-1:0]   rd_word;
  logic [SPAN_W-1:0]   span_end;
  logic                span_ok;
  logic                accept;
  logic                out_free;
  logic                commit;
  logic [STATUS_W-1:0] status_next;
  logic [DATA_W-1:0]   rdata_next;
  logic [FLAG_W-1:0]   flags_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Row of each bank for a span starting at the incoming offset
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      logic              carry;
      logic [ROWF_W-1:0] row_full;
      carry    = LANE_W'(b) < byte_offset[LANE_W-1:0];
      row_full = {1'b0, byte_offset[OFF_W-1:LANE_W]} + ROWF_W'(carry);
      row_acc[b] = ROW_W'(row_full);
    end
  end

  // Span check on the held command
  assign span_end = SPAN_W'(off_q) + SPAN_W'(cnt_q);
  assign span_ok  = (cnt_q != '0) && (cnt_q <= CNT_W'(MAX_ACCESS_BYTES)) &&
                    (span_end <= SPAN_W'(ARRAY_BYTES));

  // Map banks to bytes of the access and check for bits that would rise
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      lane_idx[b]   = LANE_W'(b) - off_q[LANE_W-1:0];
      lane_act[b]   = {1'b0, lane_idx[b]} < cnt_q;
      new_byte[b]   = data_q[lane_idx[b]*BYTE_W +: BYTE_W];
      setbit_hit[b] = lane_act[b] && ((new_byte[b] & ~bank_rdata[b]) != '0);
    end
  end

  // Gather read bytes little-endian, zero past the count
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [LANE_W-1:0] bank;
      bank = off_q[LANE_W-1:0] + LANE_W'(i);
      rd_word[i*BYTE_W +: BYTE_W] = ({1'b0, LANE_W'(i)} < cnt_q) ? bank_rdata[bank] : '0;
    end
  end

  // Decide the response for the held command
  always_comb begin
    status_next = ST_OK;
    rdata_next  = '0;
    flags_next  = flags;
    commit      = 1'b0;
    case (cmd_q)
      CMD_READ: begin
        if (!span_ok) begin
          status_next = ST_RANGE;
        end else begin
          rdata_next = rd_word;
        end
      end
      CMD_PROGRAM: begin
        if (!span_ok) begin
          status_next = ST_RANGE;
        end else if (!write_enable) begin
          status_next = ST_DISABLED;
        end else if (flags[FINAL_LOCK_BIT]) begin
          status_next = ST_LOCKED;
        end else if (setbit_hit != '0) begin
          status_next = ST_SETBIT;
        end else begin
          commit = 1'b1;
        end
      end
      CMD_SET_FLAGS: begin
        flags_next = flags | data_q[FLAG_W-1:0];
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  // Drive the banks: erase, read on transfer, or write back
  always_comb begin
    bank_ctl.rd = 1'b0;
    bank_ctl.wr = '0;
    for (int b = 0; b < LANES; b++) begin
      bank_row[b]   = row_q[b];
      bank_wdata[b] = bank_rdata[b] & new_byte[b];
    end
    case (state)
      S_CLEAR: begin
        bank_ctl.wr = '1;
        for (int b = 0; b < LANES; b++) begin
          bank_row[b]   = clr_row;
          bank_wdata[b] = ERASED_BYTE;
        end
      end
      S_IDLE: begin
        bank_ctl.rd = accept;
        for (int b = 0; b < LANES; b++) begin
          bank_row[b] = row_acc[b];
        end
      end
      S_RMW: begin
        bank_ctl.wr = (commit && out_free) ? lane_act : '0;
      end
      default: begin
        bank_ctl.wr = '0;
      end
    endcase
  end

  // Sequencer state, held command, flag word and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_RMW) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + ROW_W'(1);
          if (clr_row == ROW_W'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q  <= command;
            off_q  <= byte_offset;
            cnt_q  <= byte_count;
            data_q <= write_data;
            row_q  <= row_acc;
            state  <= S_RMW;
          end
        end
        S_RMW: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= status_next;
            read_data <= rdata_next;
            flags_now <= flags_next;
            flags     <= flags_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Bank writes happen only in the erase pass or a completing program
  assert property (@(posedge clk) disable iff (rst)
    (bank_ctl.wr != '0) |-> (state == S_CLEAR || (state == S_RMW && out_free)))
    else $error("bank write outside erase or write-back");

  // A refused or non-program command never writes the array
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW && bank_ctl.wr != '0) |->
      (cmd_q == CMD_PROGRAM && status_next == ST_OK))
    else $error("array written by a refused command");

  // Flag bits are sticky
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((flags & $past(flags)) == $past(flags)))
    else $error("flag bit cleared");

  // No command taken before the erase pass is done
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("command taken during erase pass");

  // A new response appears only when a held command completes
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_RMW))
    else $error("response without a command");

endmodule

FILE: hdl/otp_fuse_array_program_unit.sv
`timescale 1ns / 1ps
// OTP fuse array program unit: enable register, stream packing, byte banks.
// Depends on ofap_pkg, ofap_bank_ram and ofap_rmw_ctrl.
//
// Usage:
//   s_* carries commands: s_tuser is the command (read, program, set flags),
//   s_tdata the offset, byte count and program data or flag mask.
//   m_* returns one response per command: status, read bytes, flag word.
//   cfg_* writes the one-bit write enable; it is always ready and must be
//   written only while no command is in flight.
// Timing:
//   When a command is transferred the banks are read on that edge; in S_RMW
//   the checks run, and once the output register is free the write-back is
//   done and the response is registered. A new command is taken only after
//   that, since the single-port banks are read and then written back.
// Reset:
//   The array erases to 0xFF one row of all eight banks per cycle, over all
//   ROWS rows (128 at the default size), with s_tready low. Flags clear and
//   write enable sets at once.
// Stall:
//   A response waits in the output register; the next command is still
//   taken and holds after its bank read until m_tready frees the register.
module otp_fuse_array_program_unit #(
  parameter int ARRAY_BYTES      = ofap_pkg::DEFAULT_ARRAY_BYTES,
  parameter int MAX_ACCESS_BYTES = ofap_pkg::DEFAULT_MAX_ACCESS_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  // configuration write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data,    // write_enable
  // command stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,     // command
  input  logic [79:0]  s_tdata,     // byte_offset[9:0], byte_count[13:10],
                                    // write_data[77:14], zero pad[79:78]
  // response stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata      // status[2:0], read_data[66:3],
                                    // flags_now[98:67], zero pad[103:99]
);
  import ofap_pkg::*;

  localparam int ROWS  = (ARRAY_BYTES + LANES - 1) / LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic                 write_enable;
  ofap_bank_ctl_t       bank_ctl;
  logic [ROW_W-1:0]     bank_row   [LANES];
  logic [BYTE_W-1:0]    bank_wdata [LANES];
  logic [BYTE_W-1:0]    bank_rdata [LANES];
  logic [STATUS_W-1:0]  status;
  logic [DATA_W-1:0]    read_data;
  logic [FLAG_W-1:0]    flags_now;

  // Hold the write enable register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      write_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      write_enable <= cfg_data;
    end
  end

  ofap_rmw_ctrl #(
    .ARRAY_BYTES      (ARRAY_BYTES),
    .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES),
    .ROWS             (ROWS),
    .ROW_W            (ROW_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .command      (s_tuser),
    .byte_offset  (s_tdata[9:0]),
    .byte_count   (s_tdata[13:10]),
    .write_data   (s_tdata[77:14]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (status),
    .read_data    (read_data),
    .flags_now    (flags_now),
    .bank_ctl     (bank_ctl),
    .bank_row     (bank_row),
    .bank_wdata   (bank_wdata),
    .bank_rdata   (bank_rdata)
  );

  // One bank per byte lane
  for (genvar b = 0; b < LANES; b++) begin : g_bank
    ofap_bank_ram #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
    ) u_bank (
      .clk   (clk),
      .addr  (bank_row[b]),
      .rd    (bank_ctl.rd),
      .wr    (bank_ctl.wr[b]),
      .wdata (bank_wdata[b]),
      .rdata (bank_rdata[b])
    );
  end

  // Pack the response
  assign m_tdata = {5'd0, flags_now, read_data, status};

endmodule

FILE: test/fuse_response_checker.sv
`timescale 1ns / 1ps
// Response checker for the OTP fuse array program unit: keeps its own copy of
// the fuse bytes, flag word and write enable, predicts each response and compares.
// Depends on ofap_pkg for the command and status codes.
module fuse_response_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic         cfg_data,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [1:0]   s_tuser,     // command
  input  logic [79:0]  s_tdata,     // byte_offset, byte_count, write_data, zero pad
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,     // status, read_data, flags_now, zero pad
  output int           mismatch_count,
  output int           pending_responses
);
  import ofap_pkg::*;

  localparam int FUSE_BYTES   = 1024;
  localparam int ACCESS_BYTES = 8;
  localparam int RD_LSB       = STATUS_W;
  localparam int FLAGS_LSB    = STATUS_W + DATA_W;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   read_data;
    logic [FLAG_W-1:0]   flags_now;
  } fuse_response_t;

  logic [BYTE_W-1:0] fuse_bytes [FUSE_BYTES];
  logic [FLAG_W-1:0] flag_word;
  logic              write_enable;
  fuse_response_t    expected_responses [$];
  int                response_index;

  // Apply one command to the local fuse image and return the response it gives
  function automatic fuse_response_t predict_response(input logic [CMD_W-1:0] op,
                                                      input logic [OFF_W-1:0] off,
                                                      input logic [CNT_W-1:0] cnt,
                                                      input logic [DATA_W-1:0] bits);
    fuse_response_t resp;
    logic           span_bad;
    logic           would_set;
    resp.status    = ST_OK;
    resp.read_data = '0;
    span_bad = (cnt == 0) || (int'(cnt) > ACCESS_BYTES) ||
               (int'(off) + int'(cnt) > FUSE_BYTES);
    case (op)
      CMD_READ: begin
        if (span_bad) begin
          resp.status = ST_RANGE;
        end else begin
          for (int i = 0; i < int'(cnt); i++)
            resp.read_data[8*i +: 8] = fuse_bytes[int'(off) + i];
        end
      end
      CMD_PROGRAM: begin
        if (span_bad) begin
          resp.status = ST_RANGE;
        end else if (!write_enable) begin
          resp.status = ST_DISABLED;
        end else if (flag_word[FINAL_LOCK_BIT]) begin
          resp.status = ST_LOCKED;
        end else begin
          // all-or-nothing: refuse if any byte would turn a blown bit back to 1
          would_set = 1'b0;
          for (int i = 0; i < int'(cnt); i++)
            if ((bits[8*i +: 8] & ~fuse_bytes[int'(off) + i]) != '0) would_set = 1'b1;
          if (would_set) begin
            resp.status = ST_SETBIT;
          end else begin
            for (int i = 0; i < int'(cnt); i++)
              fuse_bytes[int'(off) + i] = fuse_bytes[int'(off) + i] & bits[8*i +: 8];
          end
        end
      end
      CMD_SET_FLAGS: begin
        flag_word = flag_word | bits[FLAG_W-1:0];
      end
      default: begin
        resp.status = ST_RANGE;
      end
    endcase
    resp.flags_now = flag_word;
    return resp;
  endfunction

  task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("response %0d: %s expected %h, got %h", response_index, field, want, got);
    end
  endtask

  // Track config writes, compare responses, queue predictions for new commands
  always @(posedge clk) begin
    fuse_response_t want;
    if (rst) begin
      expected_responses.delete();
      for (int i = 0; i < FUSE_BYTES; i++) fuse_bytes[i] = ERASED_BYTE;
      flag_word      = '0;
      write_enable   = 1'b1;
      mismatch_count = 0;
      response_index = 0;
    end else begin
      if (cfg_valid && cfg_ready) write_enable = cfg_data;
      if (m_tvalid && m_tready) begin
        if (expected_responses.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("response %0d: no command waiting, got %h", response_index, m_tdata);
        end else begin
          want = expected_responses.pop_front();
          check_field("status", 64'(want.status), 64'(m_tdata[RD_LSB-1:0]));
          check_field("read_data", want.read_data, m_tdata[FLAGS_LSB-1:RD_LSB]);
          check_field("flags_now", 64'(want.flags_now),
                      64'(m_tdata[FLAGS_LSB+FLAG_W-1:FLAGS_LSB]));
        end
        response_index++;
      end
      if (s_tvalid && s_tready)
        expected_responses.push_back(predict_response(s_tuser, s_tdata[9:0],
                                                      s_tdata[13:10], s_tdata[77:14]));
    end
    pending_responses = expected_responses.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Top of the OTP fuse array program unit testbench: clock, reset, command and
// config stimulus, response back-pressure and the verdict.
// Depends on ofap_pkg, otp_fuse_array_program_unit and fuse_response_checker.
module testbench;
  import ofap_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_TARGET = 1720;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_data = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [1:0]   s_tuser = '0;
  logic [79:0]  s_tdata = '0;     // byte_offset, byte_count, write_data, zero pad
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;          // status, read_data, flags_now, zero pad

  int           mismatch_count;
  int           pending_responses;
  int           cycle_count = 0;
  int           sent_count = 0;
  int           resp_count = 0;
  int           read_count = 0;
  int           program_count = 0;
  int           flag_count = 0;
  int           other_count = 0;
  int           enable_writes = 0;
  logic [63:0]  last_read_bytes = '0;

  otp_fuse_array_program_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  fuse_response_checker response_check (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .s_tuser           (s_tuser),
    .s_tdata           (s_tdata),
    .m_tvalid          (m_tvalid),
    .m_tready          (m_tready),
    .m_tdata           (m_tdata),
    .mismatch_count    (mismatch_count),
    .pending_responses (pending_responses)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Count cycles, stall the response side at random, capture read data, time out
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= 4000 && cycle_count < 7000) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 21);
    end
    if (!rst && m_tvalid && m_tready) begin
      resp_count      <= resp_count + 1;
      last_read_bytes <= m_tdata[66:3];
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d responses", cycle_count,
               resp_count, sent_count);
      $display("otp_fuse_array_program_unit: mismatch");
      $finish;
    end
  end

  // Present one command, with random idle cycles first; valid stays high on return
  task automatic send_command(input logic [CMD_W-1:0] op, input logic [OFF_W-1:0] off,
                              input logic [CNT_W-1:0] cnt, input logic [DATA_W-1:0] bits);
    logic quiet;
    quiet = (sent_count >= 600 && sent_count < 900);
    while (!quiet && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, bits, cnt, off};
    do @(posedge clk); while (!s_tready);
    sent_count++;
    case (op)
      CMD_READ:      read_count++;
      CMD_PROGRAM:   program_count++;
      CMD_SET_FLAGS: flag_count++;
      default:       other_count++;
    endcase
  endtask

  // Drop valid and hold until every response has been transferred
  task automatic wait_for_responses();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (resp_count != sent_count) @(posedge clk);
  endtask

  // Write the enable register with the unit idle
  task automatic set_write_enable(input logic value);
    wait_for_responses();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    enable_writes++;
  endtask

  initial begin
    int          pick;
    int          cnt;
    int          off;
    logic [63:0] bits;
    logic        disable_done;
    logic        enable_done;
    disable_done = 1'b0;
    enable_done  = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: span edges, bad counts, program refusals, flags, unused command
    set_write_enable(1'b1);
    send_command(CMD_READ, 10'd0, 4'd8, 64'h0);
    send_command(CMD_READ, 10'd1023, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_command(CMD_READ, 10'd1016, 4'd8, 64'h0);
    send_command(CMD_READ, 10'd1017, 4'd8, 64'h0);
    send_command(CMD_READ, 10'd0, 4'd0, 64'h0);
    send_command(CMD_READ, 10'd0, 4'd9, 64'h0);
    send_command(CMD_PROGRAM, 10'd0, 4'd15, 64'h0);
    send_command(CMD_PROGRAM, 10'd0, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_command(CMD_READ, 10'd0, 4'd8, 64'h0);
    send_command(CMD_PROGRAM, 10'd0, 4'd1, 64'hFF);
    send_command(CMD_PROGRAM, 10'd0, 4'd8, 64'h0);
    send_command(CMD_PROGRAM, 10'd1023, 4'd1, 64'h0);
    send_command(CMD_PROGRAM, 10'd1016, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    send_command(CMD_READ, 10'd1016, 4'd8, 64'h0);
    send_command(CMD_SET_FLAGS, 10'd1023, 4'd15, 64'hFFFF_FFFF_A5A5_0000);
    send_command(CMD_SET_FLAGS, 10'd0, 4'd0, 64'h0);
    send_command(CMD_UNUSED, 10'd5, 4'd3, 64'h0);
    set_write_enable(1'b0);
    send_command(CMD_PROGRAM, 10'd8, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    send_command(CMD_PROGRAM, 10'd1020, 4'd8, 64'h0);
    send_command(CMD_SET_FLAGS, 10'd0, 4'd1, 64'h0000_0F00);
    send_command(CMD_READ, 10'd8, 4'd4, 64'h0);
    set_write_enable(1'b1);

    // Random: some read-then-program pairs that only clear bits, plus noise
    while (sent_count < RANDOM_TARGET) begin
      if (!disable_done && sent_count >= 1000) begin
        set_write_enable(1'b0);
        disable_done = 1'b1;
      end
      if (!enable_done && sent_count >= 1100) begin
        set_write_enable(1'b1);
        enable_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        cnt = $urandom_range(1, 8);
        off = ($urandom_range(1) == 0) ? $urandom_range(0, 128 - cnt)
                                       : $urandom_range(0, 1024 - cnt);
        send_command(CMD_READ, OFF_W'(off), CNT_W'(cnt), {$urandom, $urandom});
        wait_for_responses();
        bits = last_read_bytes & ({$urandom, $urandom} | {$urandom, $urandom});
        send_command(CMD_PROGRAM, OFF_W'(off), CNT_W'(cnt), bits);
      end else if (pick < 82) begin
        if ($urandom_range(7) == 0) begin
          cnt = $urandom_range(0, 15);
          off = $urandom_range(0, 1023);
        end else begin
          cnt = $urandom_range(1, 8);
          off = $urandom_range(0, 1024 - cnt);
        end
        bits = ($urandom_range(3) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
        send_command((pick < 60) ? CMD_READ : CMD_PROGRAM, OFF_W'(off), CNT_W'(cnt), bits);
      end else if (pick < 94) begin
        // sparse masks, lock bit held back for the final phase
        bits = {$urandom, $urandom & $urandom & $urandom & 32'hFFFF_FFFE};
        send_command(CMD_SET_FLAGS, OFF_W'($urandom_range(0, 1023)),
                     CNT_W'($urandom_range(0, 15)), bits);
      end else begin
        cnt = ($urandom_range(1) == 0) ? 0 : 9 + $urandom_range(6);
        send_command(($urandom_range(1) == 0) ? CMD_UNUSED : CMD_READ,
                     OFF_W'($urandom_range(0, 1023)), CNT_W'(cnt),
                     {$urandom, $urandom});
      end
    end

    // Final lock: program refused as locked, disabled wins over locked, range first
    send_command(CMD_SET_FLAGS, 10'd0, 4'd1, 64'h1);
    send_command(CMD_PROGRAM, 10'd200, 4'd4, 64'h0);
    send_command(CMD_PROGRAM, 10'd300, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    send_command(CMD_PROGRAM, 10'd1022, 4'd4, 64'h0);
    send_command(CMD_READ, 10'd200, 4'd4, 64'h0);
    set_write_enable(1'b0);
    send_command(CMD_PROGRAM, 10'd200, 4'd4, 64'h0);
    send_command(CMD_PROGRAM, 10'd0, 4'd0, 64'h0);
    set_write_enable(1'b1);
    send_command(CMD_PROGRAM, 10'd1016, 4'd8, 64'h0);
    send_command(CMD_SET_FLAGS, 10'd0, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF);

    wait_for_responses();
    repeat (10) @(posedge clk);
    $display("commands: %0d reads, %0d programs, %0d flag sets, %0d invalid; %0d responses",
             read_count, program_count, flag_count, other_count, resp_count);
    $display("write enable written %0d times, lock set at the end, %0d cycles",
             enable_writes, cycle_count);
    if (mismatch_count == 0 && pending_responses == 0) begin
      $display("otp_fuse_array_program_unit: match");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatch_count, pending_responses);
      $display("otp_fuse_array_program_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: otp_fuse_array_program_unit.f
hdl/ofap_pkg.sv
hdl/ofap_bank_ram.sv
hdl/ofap_rmw_ctrl.sv
hdl/otp_fuse_array_program_unit.sv
test/fuse_response_checker.sv
test/testbench.sv
